FILE: rtl/media_packet_deframer_segmenter_macros.svh
// Assertion macros for the deframer/segmenter.
// Both expect signals named clock and reset in the using scope.
`ifndef MEDIA_PACKET_DEFRAMER_SEGMENTER_MACROS_SVH
`define MEDIA_PACKET_DEFRAMER_SEGMENTER_MACROS_SVH
`ifndef SYNTHESIS
`define MPDS_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);
`define MPDS_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define MPDS_ASSERT_NOW(lbl, pre, post, msg)
`define MPDS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: rtl/mpds_pkg.sv
`timescale 1ns / 1ps
package mpds_pkg;

   // message types and payload marks
   localparam logic [7:0]  KIND_CONTROL = 8'h00;
   localparam logic [7:0]  KIND_AUDIO   = 8'h80;
   localparam logic [7:0]  KIND_VIDEO   = 8'h90;
   localparam logic [7:0]  END_MARK     = 8'hFF;
   localparam logic [7:0]  KEY_MASK     = 8'h01;

   localparam logic [31:0] AUDIO_STEP   = 32'd20;
   localparam logic [31:0] VIDEO_OFFSET = 32'd5;

   // header_count positions
   localparam logic [3:0]  POS_TYPE          = 4'd0;
   localparam logic [3:0]  POS_LEN0          = 4'd5;
   localparam logic [3:0]  POS_LEN1          = 4'd6;
   localparam logic [3:0]  POS_LEN2          = 4'd7;
   localparam logic [3:0]  POS_LEN3          = 4'd8;
   localparam logic [3:0]  POS_FIRST_PAYLOAD = 4'd9;
   localparam logic [3:0]  POS_PAYLOAD       = 4'd10;

   // configuration register indexes
   localparam logic CSR_SEGMENT_LENGTH = 1'b0;
   localparam logic CSR_AUDIO_ONLY     = 1'b1;

   localparam logic [23:0] SEG_LEN_RESET = 24'd120000;

   typedef struct packed {
      logic [3:0]  header_count;
      logic [7:0]  message_kind;
      logic [31:0] bytes_left;
      logic [31:0] now_time;
      logic [31:0] segment_time;
      logic        keyframe_seen;
      logic        passing;
      logic        ended;
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  payload_byte;
      logic        byte_valid;
      logic        is_video;
      logic        track_number;
      logic [31:0] packet_time;
      logic        packet_first;
      logic        packet_last;
      logic        segment_cut;
      logic [31:0] segment_start;
      logic        stream_ended;
   } result_type;

endpackage

FILE: rtl/mpds_core.sv
`timescale 1ns / 1ps
module mpds_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           data_byte,
   input  logic [23:0]          segment_length_ms,
   input  logic                 audio_only,
   output mpds_pkg::result_type result,
   output logic                 ended
);

   mpds_pkg::state_type state_ff, state_in;

   always_comb begin
      logic [3:0]  hc;
      logic [31:0] diff;
      logic        elapsed;
      logic        begin_a, begin_v, finish_a, cand_data, cand_empty, cand_end;
      logic        first, last, cut;

      state_in   = state_ff;
      result     = '0;
      begin_a    = 1'b0;
      begin_v    = 1'b0;
      finish_a   = 1'b0;
      cand_data  = 1'b0;
      cand_empty = 1'b0;
      cand_end   = 1'b0;
      first      = 1'b0;
      last       = 1'b0;
      cut        = 1'b0;

      hc = (state_ff.header_count > mpds_pkg::POS_PAYLOAD) ? mpds_pkg::POS_TYPE
                                                          : state_ff.header_count;
      diff    = state_ff.now_time - state_ff.segment_time;
      elapsed = !diff[31] && (diff > {8'd0, segment_length_ms});

      if (fire && !state_ff.ended) begin
         if (hc < mpds_pkg::POS_FIRST_PAYLOAD) begin
            // header bytes; length is little endian
            case (hc)
               mpds_pkg::POS_TYPE: begin
                  state_in.message_kind = data_byte;
                  state_in.bytes_left   = '0;
               end
               mpds_pkg::POS_LEN0: state_in.bytes_left[7:0]   = state_ff.bytes_left[7:0]   | data_byte;
               mpds_pkg::POS_LEN1: state_in.bytes_left[15:8]  = state_ff.bytes_left[15:8]  | data_byte;
               mpds_pkg::POS_LEN2: state_in.bytes_left[23:16] = state_ff.bytes_left[23:16] | data_byte;
               mpds_pkg::POS_LEN3: state_in.bytes_left[31:24] = state_ff.bytes_left[31:24] | data_byte;
               default: ;
            endcase
            state_in.header_count = hc + 4'd1;
            if (state_in.header_count == mpds_pkg::POS_FIRST_PAYLOAD &&
                state_in.bytes_left == '0) begin
               // empty message
               if (state_in.message_kind == mpds_pkg::KIND_AUDIO) begin
                  begin_a    = 1'b1;
                  cand_empty = 1'b1;
                  finish_a   = 1'b1;
               end
               last = 1'b1;
            end
         end else begin
            first = (hc == mpds_pkg::POS_FIRST_PAYLOAD);
            if (first) begin
               state_in.header_count = mpds_pkg::POS_PAYLOAD;
               case (state_ff.message_kind)
                  mpds_pkg::KIND_AUDIO:   begin_a = 1'b1;
                  mpds_pkg::KIND_VIDEO:   begin_v = 1'b1;
                  mpds_pkg::KIND_CONTROL: state_in.passing = (data_byte == mpds_pkg::END_MARK);
                  default:                state_in.passing = 1'b0;
               endcase
            end
            state_in.bytes_left = state_ff.bytes_left - 32'd1;
            last = (state_in.bytes_left == '0);
            case (state_ff.message_kind)
               mpds_pkg::KIND_AUDIO:   cand_data = 1'b1;
               mpds_pkg::KIND_VIDEO:   cand_data = 1'b1;
               mpds_pkg::KIND_CONTROL: cand_end  = last;
               default: ;
            endcase
            finish_a = last && (state_ff.message_kind == mpds_pkg::KIND_AUDIO);
         end

         // packet start: cut decision
         if (begin_a) begin
            if (audio_only && elapsed) begin
               cut                    = 1'b1;
               state_in.keyframe_seen = 1'b0;
               state_in.segment_time  = state_ff.now_time;
            end
            state_in.passing = state_in.keyframe_seen || audio_only;
         end
         if (begin_v) begin
            if ((data_byte & mpds_pkg::KEY_MASK) == 8'd0) begin
               if (!audio_only && elapsed) begin
                  cut                   = 1'b1;
                  state_in.segment_time = state_ff.now_time;
               end
               state_in.keyframe_seen = 1'b1;
            end
            state_in.passing = state_in.keyframe_seen && !audio_only;
         end

         // result uses the opened segment and the pre-advance time
         if ((cand_data || cand_empty || cand_end) && state_in.passing) begin
            result.valid         = 1'b1;
            result.stream_ended  = cand_end;
            result.is_video      = cand_data && (state_ff.message_kind == mpds_pkg::KIND_VIDEO);
            result.byte_valid    = cand_data;
            result.payload_byte  = cand_data ? data_byte : 8'd0;
            result.track_number  = !cand_end && !result.is_video && !audio_only;
            result.packet_time   = result.is_video ? state_ff.now_time + mpds_pkg::VIDEO_OFFSET
                                                   : state_ff.now_time;
            result.packet_first  = !cand_end && (first || cand_empty);
            result.packet_last   = !cand_end && last;
            result.segment_cut   = !cand_end && cut;
            result.segment_start = state_in.segment_time;
            if (cand_end) state_in.ended = 1'b1;
         end

         if (finish_a) begin
            state_in.now_time = state_ff.now_time + mpds_pkg::AUDIO_STEP;
            if (!state_in.keyframe_seen && !audio_only)
               state_in.segment_time = state_in.now_time;
         end

         if (last) begin
            state_in.header_count = mpds_pkg::POS_TYPE;
            state_in.passing      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign ended = state_ff.ended;

endmodule

FILE: rtl/mpds_outreg.sv
`timescale 1ns / 1ps
module mpds_outreg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  mpds_pkg::result_type res,
   input  logic                 rsp_stall,
   output logic                 free,
   output logic                 rsp_valid,
   output mpds_pkg::result_type rsp
);

   logic                 valid_ff, valid_in;
   mpds_pkg::result_type data_ff;

   // register can load when empty or being drained this cycle
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (free) valid_in = take && res.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free && take && res.valid) data_ff <= res;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

FILE: rtl/media_packet_deframer_segmenter.sv
// A transferred byte is held in the input register, and its result (if any) in the result register.
// Throughput: one byte per cycle unless the result register stalls; per-byte state update is one registered pass.
// Back-pressure: an input register holds one byte while the result register stalls.
// Reset (synchronous, active high): empty pipeline, parser state zero,
// segment_length_ms = 120000, audio_only = 0.
`timescale 1ns / 1ps
`include "media_packet_deframer_segmenter_macros.svh"
module media_packet_deframer_segmenter (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_is_video,
   output logic        rsp_track_number,
   output logic [31:0] rsp_packet_time,
   output logic        rsp_packet_first,
   output logic        rsp_packet_last,
   output logic        rsp_segment_cut,
   output logic [31:0] rsp_segment_start,
   output logic        rsp_stream_ended,
   // configuration writes
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [23:0] csr_write_data
);

   // configuration registers
   logic [23:0] seg_len_ff;
   logic        audio_only_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_len_ff    <= mpds_pkg::SEG_LEN_RESET;
         audio_only_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            mpds_pkg::CSR_SEGMENT_LENGTH: seg_len_ff    <= csr_write_data;
            mpds_pkg::CSR_AUDIO_ONLY:     audio_only_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // input register: one byte waiting for the state update
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_free;
   logic       advance;
   logic       accept;

   // a byte moves on whenever the result register can take its outcome,
   // even if that byte yields no result
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept)       in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) in_byte_ff <= req_data_byte;
   end

   // parser / segmenter state update
   mpds_pkg::result_type res;
   mpds_pkg::result_type rsp;
   logic                 core_ended;

   mpds_core u_core (
      .clock             (clock),
      .reset             (reset),
      .fire              (advance),
      .data_byte         (in_byte_ff),
      .segment_length_ms (seg_len_ff),
      .audio_only        (audio_only_ff),
      .result            (res),
      .ended             (core_ended)
   );

   // result register
   mpds_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .take      (advance),
      .res       (res),
      .rsp_stall (rsp_stall),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_payload_byte  = rsp.payload_byte;
   assign rsp_byte_valid    = rsp.byte_valid;
   assign rsp_is_video      = rsp.is_video;
   assign rsp_track_number  = rsp.track_number;
   assign rsp_packet_time   = rsp.packet_time;
   assign rsp_packet_first  = rsp.packet_first;
   assign rsp_packet_last   = rsp.packet_last;
   assign rsp_segment_cut   = rsp.segment_cut;
   assign rsp_segment_start = rsp.segment_start;
   assign rsp_stream_ended  = rsp.stream_ended;

   // end result only after the parser has latched the end of stream
   `MPDS_ASSERT_NOW(a_end_latched, rsp_valid && rsp_stream_ended, core_ended, "end result without ended state")
   // an empty result that is not the end is a whole empty audio packet
   `MPDS_ASSERT_NOW(a_empty_packet, rsp_valid && !rsp_byte_valid && !rsp_stream_ended, rsp_packet_first && rsp_packet_last && !rsp_is_video, "malformed empty packet result")
   // a cut opens the segment at the packet's own base time
   `MPDS_ASSERT_NOW(a_cut_start, rsp_valid && rsp_segment_cut, rsp_packet_first && (rsp_segment_start == (rsp_is_video ? rsp_packet_time - mpds_pkg::VIDEO_OFFSET : rsp_packet_time)), "segment start does not match cut packet")
   // a stalled input means a byte is held and the result side is blocked
   `MPDS_ASSERT_NEXT(a_stall_hold, req_stall, in_valid_ff, "held byte lost under stall")

endmodule
